@@ hw/rtl/cpg_pkg.sv @@
`timescale 1ns / 1ps
package cpg_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int GAP_W     = VAL_W + 1;
  localparam int PAIR_W    = $clog2(MAX_ITEMS);  // up to MAX_ITEMS-1 closest pairs

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] smaller;
    logic signed [VAL_W-1:0] larger;
    logic                    pair_valid;
    logic                    overflow;
    logic                    end_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_LOW,
    ST_CHECK,
    ST_P1,
    ST_P2_START,
    ST_P2,
    ST_SHORT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DROP,
    OP_INS_SHIFT,
    OP_INS_PLACE,
    OP_INS_LOW,
    OP_P1_START,
    OP_P1_STEP,
    OP_P2_START,
    OP_P2_STEP,
    OP_SHORT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic few;
    logic greater;
    logic idx_zero;
    logic at_end;
    logic match;
    logic out_ready;
    logic last_flag;
  } status_t;

endpackage

@@ hw/rtl/cpg_ctrl.sv @@
`timescale 1ns / 1ps
module cpg_ctrl
  import cpg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (status.full) begin
          cmd.op     = OP_DROP;
          state_next = status.last_flag ? ST_CHECK : ST_IDLE;
        end else if (status.empty || !status.greater) begin
          cmd.op     = OP_INS_PLACE;
          state_next = status.last_flag ? ST_CHECK : ST_IDLE;
        end else begin
          cmd.op = OP_INS_SHIFT;
          if (status.idx_zero) begin
            state_next = ST_INS_LOW;
          end
        end
      end
      ST_INS_LOW: begin
        cmd.op     = OP_INS_LOW;
        state_next = status.last_flag ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (status.few) begin
          state_next = ST_SHORT;
        end else begin
          cmd.op     = OP_P1_START;
          state_next = ST_P1;
        end
      end
      ST_P1: begin
        cmd.op = OP_P1_STEP;
        if (status.at_end) begin
          state_next = ST_P2_START;
        end
      end
      ST_P2_START: begin
        cmd.op     = OP_P2_START;
        state_next = ST_P2;
      end
      ST_P2: begin
        // hold the compared pair while the output register is still full
        if (!(status.match && !status.out_ready)) begin
          cmd.op = OP_P2_STEP;
          if (status.at_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SHORT: begin
        if (status.out_ready) begin
          cmd.op     = OP_SHORT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/cpg_dp.sv @@
`timescale 1ns / 1ps
module cpg_dp
  import cpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [VAL_W-1:0] mem [MAX_ITEMS];
  logic [VAL_W-1:0] rdata;

  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_wdata;

  logic [CNT_W-1:0]  cnt;
  logic              drop;
  logic [GAP_W-1:0]  best;
  logic [VAL_W-1:0]  newv;
  logic              last_flag;
  logic [IDX_W-1:0]  idx;
  logic [VAL_W-1:0]  prev;
  logic [PAIR_W-1:0] nbest;
  logic [PAIR_W-1:0] remain;

  logic [IDX_W-1:0] cnt_m1;
  logic [IDX_W-1:0] idx_p1;
  logic [GAP_W-1:0] gap;
  logic             idx_zero;
  logic             at_end;
  logic             match;
  logic             out_ready;
  logic             out_load;
  logic             set_clear;

  assign cnt_m1    = IDX_W'(cnt - CNT_W'(1));
  assign idx_p1    = idx + IDX_W'(1);
  // sorted order keeps the difference in 0 .. 2^32-1
  assign gap       = {rdata[VAL_W-1], rdata} - {prev[VAL_W-1], prev};
  assign idx_zero  = (idx == '0);
  assign at_end    = (idx == cnt_m1);
  assign match     = !idx_zero && (gap == best);
  assign out_ready = !out_valid || !out_stall;
  assign out_load  = ((cmd.op == OP_P2_STEP) && match) || (cmd.op == OP_SHORT);
  assign set_clear = ((cmd.op == OP_P2_STEP) && at_end) || (cmd.op == OP_SHORT);

  assign status.full      = (cnt == CNT_W'(MAX_ITEMS));
  assign status.empty     = (cnt == '0);
  assign status.few       = (cnt < CNT_W'(2));
  assign status.greater   = ($signed(rdata) > $signed(newv));
  assign status.idx_zero  = idx_zero;
  assign status.at_end    = at_end;
  assign status.match     = match;
  assign status.out_ready = out_ready;
  assign status.last_flag = last_flag;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_p1;
    mem_raddr = idx_p1;
    mem_wdata = newv;
    case (cmd.op)
      OP_ACCEPT: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_m1;
      end
      OP_INS_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = rdata;
        mem_re    = !idx_zero;
        mem_raddr = idx - IDX_W'(1);
      end
      OP_INS_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = status.empty ? '0 : idx_p1;
      end
      OP_INS_LOW: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
      end
      OP_P1_START, OP_P2_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      OP_P1_STEP, OP_P2_STEP: begin
        mem_re = !at_end;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // set-level control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      drop      <= 1'b0;
      best      <= '1;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (set_clear) begin
        cnt  <= '0;
        drop <= 1'b0;
        best <= '1;
      end else begin
        case (cmd.op)
          OP_DROP: drop <= 1'b1;
          OP_INS_PLACE, OP_INS_LOW: cnt <= cnt + CNT_W'(1);
          OP_P1_START: best <= '1;
          OP_P1_STEP: begin
            if (!idx_zero && (gap < best)) begin
              best <= gap;
            end
          end
          default: begin
            cnt <= cnt;
          end
        endcase
      end
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        newv      <= in_data.value;
        last_flag <= in_data.last;
        idx       <= cnt_m1;
      end
      OP_INS_SHIFT: begin
        if (!idx_zero) begin
          idx <= idx - IDX_W'(1);
        end
      end
      OP_P1_START: begin
        idx   <= '0;
        nbest <= '0;
      end
      OP_P1_STEP: begin
        if (!idx_zero) begin
          if (gap < best) begin
            nbest <= PAIR_W'(1);
          end else if (gap == best) begin
            nbest <= nbest + PAIR_W'(1);
          end
        end
        prev <= rdata;
        if (!at_end) begin
          idx <= idx_p1;
        end
      end
      OP_P2_START: begin
        idx    <= '0;
        remain <= nbest;
      end
      OP_P2_STEP: begin
        if (match) begin
          out_data.smaller    <= prev;
          out_data.larger     <= rdata;
          out_data.pair_valid <= 1'b1;
          out_data.overflow   <= drop;
          out_data.end_of_run <= (remain == PAIR_W'(1));
          remain              <= remain - PAIR_W'(1);
        end
        prev <= rdata;
        if (!at_end) begin
          idx <= idx_p1;
        end
      end
      OP_SHORT: begin
        out_data.smaller    <= '0;
        out_data.larger     <= '0;
        out_data.pair_valid <= 1'b0;
        out_data.overflow   <= drop;
        out_data.end_of_run <= 1'b1;
      end
      default: begin
        prev <= prev;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_ITEMS))
    else $error("store count beyond capacity");

  a_remain_live: assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == OP_P2_STEP) && match) |-> (remain != '0))
    else $error("closest pair found with no pairs left to emit");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == OP_P1_STEP) || (cmd.op == OP_P2_STEP)) |-> ({1'b0, idx} < cnt))
    else $error("scan index past stored values");

  a_last_pair_end: assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == OP_P2_STEP) && at_end) |-> (!match || (remain == PAIR_W'(1))))
    else $error("final pair of set not flagged as end of run");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    set_clear |=> ((cnt == '0) && !drop))
    else $error("set state not cleared after run");
`endif

endmodule

@@ hw/rtl/closest_pair_gap_finder_core.sv @@
`timescale 1ns / 1ps
// Closest adjacent pair finder.
// Input channel (in_valid / in_stall / in_data): one signed 32-bit value per beat,
// in_data.last marks the final value of a set. A beat is taken when valid is
// high and stall is low; in_stall is low only while the block is idle.
// Each value is inserted into a sorted 64-entry store, each larger entry moved
// up one place in turn through the single write port of the store. Values
// beyond 64 are dropped and flagged.
// After the last beat the store is scanned twice, one entry per cycle through
// the registered read port: a pass for the smallest gap, then a pass emitting
// each pair with that gap, pausing on a pair while the output register is full.
// Output channel (out_valid / out_stall / out_data): one beat per closest pair
// in ascending order, end_of_run on the final one. A set of fewer than two
// values gives one beat with pair_valid low.
// Results sit in an output register; while the receiver stalls it holds its
// beat and the scan waits on the next matching pair.
// Synchronous reset empties the set and drops any pending result; store
// contents are left as is and never used before being written.
module closest_pair_gap_finder_core
  import cpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer: insertion steps, gap pass, emit pass
  cpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // sorted store, gap compare and output register
  cpg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ dv/pair_gap_checker.sv @@
`timescale 1ns / 1ps
module pair_gap_checker
  import cpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        expected_left,
  output int        results_seen
);

  // Own copy of the set: ascending values, count and drop flag.
  logic signed [VAL_W-1:0] sorted_vals [MAX_ITEMS];
  int unsigned             n_vals;
  logic                    set_dropped;
  out_item_t               closest_pairs_q [$];
  int                      errs;
  int                      beats;

  task automatic load_value(input logic signed [VAL_W-1:0] v);
    int unsigned pos;
    if (n_vals >= MAX_ITEMS) begin
      set_dropped = 1'b1;
      return;
    end
    pos = n_vals;
    while (pos > 0 && sorted_vals[pos-1] > v) begin
      sorted_vals[pos] = sorted_vals[pos-1];
      pos--;
    end
    sorted_vals[pos] = v;
    n_vals++;
  endtask

  // 33-bit gap between neighbors i and i+1, never negative
  function automatic logic [GAP_W-1:0] gap_at(input int unsigned i);
    return {sorted_vals[i+1][VAL_W-1], sorted_vals[i+1]} -
           {sorted_vals[i][VAL_W-1], sorted_vals[i]};
  endfunction

  task automatic predict_closest_pairs();
    logic [GAP_W-1:0] best;
    int unsigned      last_idx;
    out_item_t        r;
    r = '0;
    r.overflow = set_dropped;
    if (n_vals < 2) begin
      r.end_of_run = 1'b1;
      closest_pairs_q.insert(closest_pairs_q.size(), r);
    end else begin
      best = '1;
      last_idx = 0;
      for (int unsigned i = 0; i + 1 < n_vals; i++)
        if (gap_at(i) < best) best = gap_at(i);
      for (int unsigned i = 0; i + 1 < n_vals; i++)
        if (gap_at(i) == best) last_idx = i;
      for (int unsigned i = 0; i + 1 < n_vals; i++) begin
        if (gap_at(i) == best) begin
          r.smaller    = sorted_vals[i];
          r.larger     = sorted_vals[i+1];
          r.pair_valid = 1'b1;
          r.end_of_run = (i == last_idx);
          closest_pairs_q.insert(closest_pairs_q.size(), r);
        end
      end
    end
    n_vals = 0;
    set_dropped = 1'b0;
  endtask

  function automatic bit field_matches(input string name,
                                       input logic signed [VAL_W:0] want,
                                       input logic signed [VAL_W:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    bit        ok;
    if (rst) begin
      n_vals = 0;
      set_dropped = 1'b0;
      closest_pairs_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        beats++;
        if (closest_pairs_q.size() == 0) begin
          $error("result beat with nothing expected: smaller %0d larger %0d",
                 out_data.smaller, out_data.larger);
          errs++;
        end else begin
          want = closest_pairs_q.pop_front();
          ok = field_matches("smaller", want.smaller, out_data.smaller) &
               field_matches("larger", want.larger, out_data.larger) &
               field_matches("pair_valid", want.pair_valid, out_data.pair_valid) &
               field_matches("overflow", want.overflow, out_data.overflow) &
               field_matches("end_of_run", want.end_of_run, out_data.end_of_run);
          if (!ok) errs++;
        end
      end
      if (in_valid && !in_stall) begin
        load_value(in_data.value);
        if (in_data.last) predict_closest_pairs();
      end
    end
    fail_count    <= errs;
    expected_left <= closest_pairs_q.size();
    results_seen  <= beats;
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import cpg_pkg::*;

  // 4 ns clock; every input starts at a known value
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int expected_left;
  int results_seen;

  // run bookkeeping, used for the hold-off trigger and the summary
  int items_sent;
  int sets_sent;
  int short_sets;
  int overfull_sets;
  bit quiet = 1'b0;   // no idling on either side once set (tail of the run)
  bit calm  = 1'b0;   // idle-free windows, each one drawn at random

  // values that sit on the sign boundary and the ends of the range
  int edge_vals [7] = '{32'sh8000_0000, 32'sh8000_0001, -1, 0, 1,
                        32'sh7fff_fffe, 32'sh7fff_ffff};

  always #2 clk = ~clk;

  closest_pair_gap_finder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pair_gap_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .expected_left (expected_left),
    .results_seen  (results_seen)
  );

  // Sends one set, the final value marked last. All driving happens right after
  // a rising edge with NBAs; in_stall is read at the edge, so it is the value
  // the block saw when it decided to take the beat. valid stays high between
  // back-to-back beats (one NBA per step) and drops only for a sender gap.
  task automatic send_set(input int vals [$]);
    for (int i = 0; i < vals.size(); i++) begin
      if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{value: vals[i], last: (i == vals.size() - 1)};
      @(posedge clk);
      while (in_stall) @(posedge clk);
      items_sent++;
    end
    sets_sent++;
    if (vals.size() < 2) short_sets++;
    if (vals.size() > MAX_ITEMS) overfull_sets++;
  endtask

  // Random set of n values. Most modes crowd values together so that
  // several pairs tie for the smallest gap.
  task automatic random_set(input int n);
    int vals [$];
    int mode;
    int base;
    int step;
    int j;
    int tmp;
    mode = $urandom_range(0, 3);
    base = $urandom;
    step = $urandom_range(0, 1000);
    for (int k = 0; k < n; k++) begin
      case (mode)
        0: vals.insert(vals.size(), $urandom);
        1: vals.insert(vals.size(), base + $urandom_range(0, 15));
        2: vals.insert(vals.size(), base + k * step);   // evenly spaced: all gaps tie
        default: vals.insert(vals.size(), $urandom_range(0, 2) == 0 ?
                                          $urandom : edge_vals[$urandom_range(0, 6)]);
      endcase
    end
    // shuffle so insertion sees random arrival order
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = vals[k];
      vals[k] = vals[j];
      vals[j] = tmp;
    end
    send_set(vals);
  endtask

  // Redraw the idle-free windows now and then.
  initial begin
    forever begin
      repeat (150) @(posedge clk);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // Receiver: short random stalls, plus one long hold-off once the run is
  // under way. During that hold the sender keeps offering, so the block ends
  // up with a result stuck in its output register and stalls its input.
  initial begin : rx_side
    int  hold_cnt;
    bit  long_done;
    hold_cnt  = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt == 0 && !quiet) begin
        if (!long_done && items_sent >= 120) begin
          hold_cnt  = 500;
          long_done = 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          hold_cnt = $urandom_range(1, 6);
        end
      end
      out_stall <= (hold_cnt != 0);
      if (hold_cnt != 0) hold_cnt--;
    end
  end

  initial begin : stimulus
    int  vals [$];
    bit  full_done;
    bit  over_done;
    int  step;
    full_done = 1'b0;
    over_done = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed sets ---
    vals = {5};                                   // single value: no pair
    send_set(vals);
    vals = {32'sh7fff_ffff, 32'sh8000_0000};      // widest gap, needs 33 bits
    send_set(vals);
    vals = {0, 0};                                // equal values, gap 0
    send_set(vals);
    vals = {3, 1, 7, 5, 9};                       // four pairs tie
    send_set(vals);
    vals = {100, 50, 49, -3, 48};                 // mostly falling order, two ties
    send_set(vals);
    vals = {-1, 32'sh8000_0000, 1, 32'sh7fff_ffff, 0};  // across the sign boundary
    send_set(vals);
    vals = {32'sh8000_0001, 32'sh8000_0000, 32'sh7fff_fffe, 32'sh7fff_ffff};
    send_set(vals);

    // --- random sets ---
    while (items_sent < 310) begin
      if (items_sent >= 260) quiet <= 1'b1;
      if (!full_done && items_sent >= 60) begin
        // exactly full store, falling order: every insert shifts the whole
        // store and all 63 gaps tie, the most results a set can give
        step = $urandom_range(1, 32'h000f_ffff);
        vals.delete();
        for (int k = MAX_ITEMS - 1; k >= 0; k--)
          vals.insert(vals.size(), k * step - 32'sh0100_0000);
        send_set(vals);
        full_done = 1'b1;
      end else if (!over_done && items_sent >= 140) begin
        // two past capacity: the tail, last beat included, is dropped
        random_set(MAX_ITEMS + 2);
        over_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        random_set(1);
      end else begin
        random_set($urandom_range(2, 12));
      end
    end

    // drain: let the checker's count reflect the final set before waiting on it
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d sets (%0d values): %0d with a single value, %0d past capacity.",
             sets_sent, items_sent, short_sets, overfull_sets);
    $display("Checked %0d result beats against the predicted closest pairs.", results_seen);
    if (fail_count == 0 && expected_left == 0) begin
      $display("closest_pair_gap_finder_core test passed");
    end else begin
      $display("closest_pair_gap_finder_core test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("closest_pair_gap_finder_core test failed");
    $finish;
  end

endmodule
